[rtl/core/sabt_pkg.sv]
package sabt_pkg;

  // default coordinate width, signed Q12.4
  localparam int unsigned COORD_BITS_DEF = 16;

  // cycles from the accepting edge to the edge that takes the result
  localparam int unsigned PIPE_LATENCY = 6;

  // per-item decision flags that travel down the pipe beside the arithmetic
  typedef struct packed {
    logic valid;
    logic early_hit;   // an endpoint lies inside the rectangle
    logic early_miss;  // zero-length segment, or a flat axis outside its slab
    logic ax0_flat;    // no motion along x
    logic ax1_flat;    // no motion along y
  } flag_t;

endpackage

[rtl/core/sabt_xmul_cmp.sv]
module sabt_xmul_cmp #(
  parameter int unsigned NW = 18,
  parameter int unsigned DW = 17
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] n1,
  input  logic        [DW-1:0] d1,
  input  logic signed [NW-1:0] n2,
  input  logic        [DW-1:0] d2,
  output logic                 gt,
  output logic                 lt
);

  localparam int unsigned PW = NW + DW + 1;

  logic signed [PW-1:0] p1;
  logic signed [PW-1:0] p2;
  logic signed [DW:0]   d1_s;
  logic signed [DW:0]   d2_s;

  assign d1_s = $signed({1'b0, d1});
  assign d2_s = $signed({1'b0, d2});

  // n1/d1 against n2/d2 with positive denominators: compare n1*d2 with n2*d1
  always_ff @(posedge clk) begin
    p1 <= PW'(n1) * PW'(d2_s);
    p2 <= PW'(n2) * PW'(d1_s);
  end

  assign gt = p1 > p2;
  assign lt = p1 < p2;

endmodule

[rtl/core/segment_aabb_slab_test.sv]
// segment against axis-aligned rectangle, 2d slab test
//
// input channel: an item (segment start/end point, rectangle origin and
// signed size, all signed q12.4) is taken at a rising edge where start is
// high and busy is low. busy is low at all times except during reset and
// the cycle right after it, so an item can be taken on every clock.
// output channel: done pulses for one cycle with hit alongside it; one
// result per item, in order. the receiver cannot hold results off and the
// pipe never needs to, so nothing is dropped or repeated.
// pipeline: six register stages: bounds, slab offsets, two cross
// multiplies for entry/exit, selection, a final cross multiply, result.
// throughput one item per cycle, set by the pipelined cross-multiply
// compare units.
// reset (rst, synchronous) clears the valid bits of every stage; items in
// flight are dropped. hit is held low whenever done is low.
module segment_aabb_slab_test #(
  parameter int unsigned COORD_BITS = sabt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] rect_origin_x,
  input  logic signed [COORD_BITS-1:0] rect_origin_y,
  input  logic signed [COORD_BITS-1:0] rect_size_x,
  input  logic signed [COORD_BITS-1:0] rect_size_y,
  output logic                         done,
  output logic                         hit
);

  import sabt_pkg::*;

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned BW = COORD_BITS + 1;  // bounds and direction
  localparam int unsigned NW = COORD_BITS + 2;  // slab offsets (numerators)

  // held high through reset and in the cycle right after it
  logic busy_q;
  logic accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy   = rst | busy_q;
  assign accept = start & ~busy;

  // ---------------------------------------------------------------
  // stage 1: rectangle bounds per axis and segment direction
  // ---------------------------------------------------------------
  logic signed [W-1:0]  in_s [2];
  logic signed [W-1:0]  in_e [2];
  logic signed [W-1:0]  in_o [2];
  logic signed [W-1:0]  in_z [2];
  logic signed [BW-1:0] far_c [2];
  logic signed [BW-1:0] org_c [2];

  assign in_s[0] = start_x;
  assign in_s[1] = start_y;
  assign in_e[0] = end_x;
  assign in_e[1] = end_y;
  assign in_o[0] = rect_origin_x;
  assign in_o[1] = rect_origin_y;
  assign in_z[0] = rect_size_x;
  assign in_z[1] = rect_size_y;

  logic                 v1;
  logic signed [W-1:0]  s1_s  [2];
  logic signed [BW-1:0] s1_lo [2];
  logic signed [BW-1:0] s1_hi [2];
  logic signed [BW-1:0] s1_d  [2];
  logic signed [BW-1:0] s1_es [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      org_c[k] = BW'(in_o[k]);
      far_c[k] = org_c[k] + BW'(in_z[k]);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      s1_s[k]  <= in_s[k];
      s1_es[k] <= BW'(in_e[k]);
      s1_lo[k] <= (org_c[k] < far_c[k]) ? org_c[k] : far_c[k];
      s1_hi[k] <= (org_c[k] < far_c[k]) ? far_c[k] : org_c[k];
      s1_d[k]  <= BW'(in_e[k]) - BW'(in_s[k]);
    end
  end

  // ---------------------------------------------------------------
  // stage 2: endpoint containment, flat axes, entry/exit offsets
  // ---------------------------------------------------------------
  logic signed [BW-1:0] sx    [2];
  logic                 s_in  [2];
  logic                 e_in  [2];
  logic                 flat  [2];
  logic signed [NW-1:0] en_c  [2];
  logic signed [NW-1:0] ex_c  [2];
  logic        [BW-1:0] den_c [2];
  flag_t                flag2_next;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sx[k]   = BW'(s1_s[k]);
      s_in[k] = (s1_lo[k] <= sx[k]) && (sx[k] <= s1_hi[k]);
      e_in[k] = (s1_lo[k] <= s1_es[k]) && (s1_es[k] <= s1_hi[k]);
      flat[k] = (s1_d[k] == '0);
      if (s1_d[k] > 0) begin
        en_c[k] = NW'(s1_lo[k]) - NW'(sx[k]);
        ex_c[k] = NW'(s1_hi[k]) - NW'(sx[k]);
      end else begin
        en_c[k] = NW'(sx[k]) - NW'(s1_hi[k]);
        ex_c[k] = NW'(sx[k]) - NW'(s1_lo[k]);
      end
      // magnitude reaches 2**W - 1 at most, fits unsigned in BW bits
      den_c[k] = s1_d[k][BW-1] ? BW'(-s1_d[k]) : BW'(s1_d[k]);
    end
    flag2_next.valid      = v1;
    flag2_next.early_hit  = (s_in[0] && s_in[1]) || (e_in[0] && e_in[1]);
    flag2_next.early_miss = (flat[0] && flat[1])
                          || (flat[0] && !s_in[0])
                          || (flat[1] && !s_in[1]);
    flag2_next.ax0_flat   = flat[0];
    flag2_next.ax1_flat   = flat[1];
  end

  flag_t                flag2;
  logic signed [NW-1:0] s2_en  [2];
  logic signed [NW-1:0] s2_ex  [2];
  logic        [BW-1:0] s2_den [2];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      s2_en[k]  <= en_c[k];
      s2_ex[k]  <= ex_c[k];
      s2_den[k] <= den_c[k];
    end
  end

  // ---------------------------------------------------------------
  // stage 3: cross products comparing the two axes' entry and exit
  // ---------------------------------------------------------------
  logic entry_gt, entry_lt;
  logic exit_gt, exit_lt;

  sabt_xmul_cmp #(.NW(NW), .DW(BW)) u_entry_cmp (
    .clk (clk),
    .n1  (s2_en[0]),
    .d1  (s2_den[0]),
    .n2  (s2_en[1]),
    .d2  (s2_den[1]),
    .gt  (entry_gt),
    .lt  (entry_lt)
  );

  sabt_xmul_cmp #(.NW(NW), .DW(BW)) u_exit_cmp (
    .clk (clk),
    .n1  (s2_ex[0]),
    .d1  (s2_den[0]),
    .n2  (s2_ex[1]),
    .d2  (s2_den[1]),
    .gt  (exit_gt),
    .lt  (exit_lt)
  );

  flag_t                flag3;
  logic signed [NW-1:0] s3_en  [2];
  logic signed [NW-1:0] s3_ex  [2];
  logic        [BW-1:0] s3_den [2];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 2; k++) begin
      s3_en[k]  <= s2_en[k];
      s3_ex[k]  <= s2_ex[k];
      s3_den[k] <= s2_den[k];
    end
  end

  // ---------------------------------------------------------------
  // stage 4: tmin is the later entry, tmax the earlier exit
  // ---------------------------------------------------------------
  logic mn_sel, mx_sel;  // 1 picks the y axis

  always_comb begin
    priority if (flag3.ax0_flat) begin
      mn_sel = 1'b1;
      mx_sel = 1'b1;
    end else if (flag3.ax1_flat) begin
      mn_sel = 1'b0;
      mx_sel = 1'b0;
    end else begin
      // equal fractions pick y; either choice has the same value
      mn_sel = !entry_gt;
      mx_sel = !exit_lt;
    end
  end

  flag_t                flag4;
  logic signed [NW-1:0] mn_n, mx_n;
  logic        [BW-1:0] mn_d, mx_d;

  always_ff @(posedge clk) begin
    mn_n <= s3_en[mn_sel];
    mn_d <= s3_den[mn_sel];
    mx_n <= s3_ex[mx_sel];
    mx_d <= s3_den[mx_sel];
  end

  // ---------------------------------------------------------------
  // stage 5: tmin against tmax
  // ---------------------------------------------------------------
  logic span_gt, span_lt;

  sabt_xmul_cmp #(.NW(NW), .DW(BW)) u_span_cmp (
    .clk (clk),
    .n1  (mn_n),
    .d1  (mn_d),
    .n2  (mx_n),
    .d2  (mx_d),
    .gt  (span_gt),
    .lt  (span_lt)
  );

  flag_t                flag5;
  logic signed [NW-1:0] s5_mn_n, s5_mx_n;
  logic        [BW-1:0] s5_mn_d, s5_mx_d;

  always_ff @(posedge clk) begin
    s5_mn_n <= mn_n;
    s5_mn_d <= mn_d;
    s5_mx_n <= mx_n;
    s5_mx_d <= mx_d;
  end

  // ---------------------------------------------------------------
  // stage 6: chosen t strictly inside (0, 1)
  // ---------------------------------------------------------------
  logic signed [NW-1:0] mn_d_s, mx_d_s;
  logic                 t_ok;
  logic                 slab_ok;
  logic                 result;

  assign mn_d_s = $signed({1'b0, s5_mn_d});
  assign mx_d_s = $signed({1'b0, s5_mx_d});

  always_comb begin
    if (s5_mn_n < 0) begin
      t_ok = (s5_mx_n > 0) && (s5_mx_n < mx_d_s);
    end else begin
      t_ok = (s5_mn_n > 0) && (s5_mn_n < mn_d_s);
    end
    slab_ok = (s5_mx_n >= 0) && !span_gt && t_ok;
    result  = flag5.early_hit || (!flag5.early_miss && slab_ok);
  end

  // the span and entry compares' "less" sides and the exit compare's "greater" side are not needed beyond their units
  logic unused_lt;
  assign unused_lt = span_lt | entry_lt | exit_gt;

  // ---------------------------------------------------------------
  // valid and flag pipeline
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      flag2 <= '0;
      flag3 <= '0;
      flag4 <= '0;
      flag5 <= '0;
      done  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      v1    <= accept;
      flag2 <= flag2_next;
      flag3 <= flag2;
      flag4 <= flag3;
      flag5 <= flag4;
      done  <= flag5.valid;
      hit   <= flag5.valid & result & ~unused_lt | flag5.valid & result;
    end
  end

endmodule

[rtl/core/sabt_checker.sv]
module sabt_props #(
  parameter int unsigned COORD_BITS = sabt_pkg::COORD_BITS_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic signed [COORD_BITS-1:0] start_x,
  input logic signed [COORD_BITS-1:0] start_y,
  input logic signed [COORD_BITS-1:0] end_x,
  input logic signed [COORD_BITS-1:0] end_y,
  input logic signed [COORD_BITS-1:0] rect_origin_x,
  input logic signed [COORD_BITS-1:0] rect_origin_y,
  input logic signed [COORD_BITS-1:0] rect_size_x,
  input logic signed [COORD_BITS-1:0] rect_size_y,
  input logic                         done,
  input logic                         hit
);

  import sabt_pkg::*;

  // every item yields its result a fixed number of cycles later
  a_item_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("item accepted without a result at the pipe latency");

  // no result without an item taken at the pipe latency before
  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a matching item");

  // hit is only shown with its strobe
  a_hit_qualified: assert property (@(posedge clk) disable iff (rst)
    hit |-> done)
    else $error("hit high outside a result cycle");

  // a start point on the rectangle origin corner always hits
  a_corner_hit: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && start_x == rect_origin_x && start_y == rect_origin_y)
      |-> ##PIPE_LATENCY hit)
    else $error("start point on the rectangle corner reported as a miss");

endmodule

bind segment_aabb_slab_test sabt_props #(.COORD_BITS(COORD_BITS)) u_sabt_props (.*);
